// ----- hdl/sbot_pkg.sv -----
// shared constants and types for the segment versus box overlap test
`default_nettype none

package sbot_pkg;

  localparam int COORD_BITS_DEF = 16;

  // axis pairs for the three cross-product separating axes (x cross, y cross, z cross)
  localparam int AXIS_A [3] = '{1, 2, 0};
  localparam int AXIS_B [3] = '{2, 0, 1};

  // per-stage load enables, driven by the stall chain in the top level
  typedef struct packed {
    logic prep;
    logic axis;
    logic mul;
    logic sum;
  } stage_en_t;

endpackage

`default_nettype wire

// ----- hdl/segment_box_overlap_test_unit.sv -----
// top level: segment versus axis-aligned box overlap test, five register stages
// flow: an input moves through the prep, axis, mul and sum registers into the output register
// throughput: one item per cycle while out_stall is low; each stage refills as soon as its item moves on,
// so bubbles close up under an output stall and in_stall rises only when all stages are full
// reset: clears the stage valid bits and out_valid; data registers are not reset
`default_nettype none

module segment_box_overlap_test_unit #(
  parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_start_z,
  input  wire logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_end_z,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_x,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_y,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_z,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_x,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_y,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_z,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_overlaps
);

  localparam int TW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 4;

  sbot_pkg::stage_en_t en;
  logic en_out;

  logic v_prep_r, v_axis_r, v_mul_r, v_sum_r, out_valid_r;
  logic v_prep_nxt, v_axis_nxt, v_mul_nxt, v_sum_nxt, out_valid_nxt;

  logic signed [COORD_BITS-1:0] seg_start [3];
  logic signed [COORD_BITS-1:0] seg_end   [3];
  logic signed [COORD_BITS-1:0] box_min   [3];
  logic signed [COORD_BITS-1:0] box_max   [3];

  logic signed [TW-1:0] t_p [3];
  logic signed [EW-1:0] e_p [3];
  logic signed [EW-1:0] d_p [3];
  logic signed [TW-1:0] t_a [3];
  logic signed [EW-1:0] e_a [3];
  logic signed [EW-1:0] d_a [3];
  logic        [EW-1:0] dmag_a [3];
  logic                 sep_a;
  logic signed [PW-1:0] diff_s [3];
  logic signed [PW-1:0] rad_s [3];
  logic                 sep_s;

  logic signed [PW:0]   near_sum [3];
  logic                 sep_fin;
  logic                 overlaps_r, overlaps_nxt;

  assign seg_start = '{in_seg_start_x, in_seg_start_y, in_seg_start_z};
  assign seg_end   = '{in_seg_end_x, in_seg_end_y, in_seg_end_z};
  assign box_min   = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign box_max   = '{in_box_max_x, in_box_max_y, in_box_max_z};

  // a stage loads when it is empty or its item moves on in the same cycle
  always_comb begin
    en_out   = !out_valid_r || !out_stall;
    en.sum   = !v_sum_r || en_out;
    en.mul   = !v_mul_r || en.sum;
    en.axis  = !v_axis_r || en.mul;
    en.prep  = !v_prep_r || en.axis;
    in_stall = !en.prep;
  end

  always_comb begin
    v_prep_nxt    = en.prep ? in_valid : v_prep_r;
    v_axis_nxt    = en.axis ? v_prep_r : v_axis_r;
    v_mul_nxt     = en.mul ? v_axis_r : v_mul_r;
    v_sum_nxt     = en.sum ? v_mul_r : v_sum_r;
    out_valid_nxt = en_out ? v_sum_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_prep_r    <= 1'b0;
      v_axis_r    <= 1'b0;
      v_mul_r     <= 1'b0;
      v_sum_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_prep_r    <= v_prep_nxt;
      v_axis_r    <= v_axis_nxt;
      v_mul_r     <= v_mul_nxt;
      v_sum_r     <= v_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sbot_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk       (clk),
    .en        (en),
    .seg_start (seg_start),
    .seg_end   (seg_end),
    .box_min   (box_min),
    .box_max   (box_max),
    .t_r       (t_p),
    .e_r       (e_p),
    .d_r       (d_p)
  );

  sbot_axis #(.COORD_BITS(COORD_BITS)) u_axis (
    .clk    (clk),
    .en     (en),
    .t      (t_p),
    .e      (e_p),
    .d      (d_p),
    .t_r    (t_a),
    .e_r    (e_a),
    .d_r    (d_a),
    .dmag_r (dmag_a),
    .sep_r  (sep_a)
  );

  sbot_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk    (clk),
    .en     (en),
    .t      (t_a),
    .e      (e_a),
    .d      (d_a),
    .dmag   (dmag_a),
    .sep_in (sep_a),
    .diff_r (diff_s),
    .rad_r  (rad_s),
    .sep_r  (sep_s)
  );

  // |diff| > rad splits into diff > rad or diff + rad < 0, no absolute value needed
  always_comb begin
    sep_fin = sep_s;
    for (int k = 0; k < 3; k++) begin
      near_sum[k] = (PW+1)'(diff_s[k]) + (PW+1)'(rad_s[k]);
      sep_fin     = sep_fin | (diff_s[k] > rad_s[k]) | near_sum[k][PW];
    end
    overlaps_nxt = !sep_fin;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      overlaps_r <= overlaps_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_overlaps = overlaps_r;

  // input backs up only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_prep_r && v_axis_r && v_mul_r && v_sum_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  // an item held in the multiply stage is not dropped
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_mul_r && !en.mul) |=> v_mul_r)
    else $error("multiply stage lost an item while held");

  // a finished item leaving the sum stage shows up at the output
  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_sum_r && en_out) |=> out_valid_r)
    else $error("sum stage item did not reach the output register");

endmodule

`default_nettype wire

// ----- hdl/sbot_prep.sv -----
// first stage: doubled center offset, doubled extent and segment vector per axis
`default_nettype none

module sbot_prep #(
  parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire sbot_pkg::stage_en_t             en,
  input  wire logic signed [COORD_BITS-1:0]    seg_start [3],
  input  wire logic signed [COORD_BITS-1:0]    seg_end   [3],
  input  wire logic signed [COORD_BITS-1:0]    box_min   [3],
  input  wire logic signed [COORD_BITS-1:0]    box_max   [3],
  output logic signed [COORD_BITS+1:0]         t_r [3],
  output logic signed [COORD_BITS:0]           e_r [3],
  output logic signed [COORD_BITS:0]           d_r [3]
);

  localparam int TW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 1;

  logic signed [TW-1:0] t_nxt [3];
  logic signed [EW-1:0] e_nxt [3];
  logic signed [EW-1:0] d_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = (TW'(box_min[i]) + TW'(box_max[i])) - (TW'(seg_start[i]) + TW'(seg_end[i]));
      e_nxt[i] = EW'(box_max[i]) - EW'(box_min[i]);
      d_nxt[i] = EW'(seg_end[i]) - EW'(seg_start[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.prep) begin
      t_r <= t_nxt;
      e_r <= e_nxt;
      d_r <= d_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sbot_axis.sv -----
// second stage: magnitudes and the three box-axis separation tests
`default_nettype none

module sbot_axis #(
  parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire sbot_pkg::stage_en_t             en,
  input  wire logic signed [COORD_BITS+1:0]    t [3],
  input  wire logic signed [COORD_BITS:0]      e [3],
  input  wire logic signed [COORD_BITS:0]      d [3],
  output logic signed [COORD_BITS+1:0]         t_r [3],
  output logic signed [COORD_BITS:0]           e_r [3],
  output logic signed [COORD_BITS:0]           d_r [3],
  output logic        [COORD_BITS:0]           dmag_r [3],
  output logic                                 sep_r
);

  localparam int TW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 1;
  localparam int CW = COORD_BITS + 3;

  logic        [TW-1:0] tmag [3];
  logic        [EW-1:0] dmag_nxt [3];
  logic signed [CW-1:0] lhs [3];
  logic signed [CW-1:0] rhs [3];
  logic                 sep_nxt;

  always_comb begin
    sep_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tmag[i]     = t[i][TW-1] ? TW'(-t[i]) : TW'(t[i]);
      dmag_nxt[i] = d[i][EW-1] ? EW'(-d[i]) : EW'(d[i]);
      lhs[i]      = CW'($signed({1'b0, tmag[i]}));
      rhs[i]      = CW'(e[i]) + CW'($signed({1'b0, dmag_nxt[i]}));
      sep_nxt     = sep_nxt | (lhs[i] > rhs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.axis) begin
      t_r    <= t;
      e_r    <= e;
      d_r    <= d;
      dmag_r <= dmag_nxt;
      sep_r  <= sep_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sbot_cross.sv -----
// third and fourth stages: cross-axis products, then projected distance and radius
`default_nettype none

module sbot_cross #(
  parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire sbot_pkg::stage_en_t             en,
  input  wire logic signed [COORD_BITS+1:0]    t [3],
  input  wire logic signed [COORD_BITS:0]      e [3],
  input  wire logic signed [COORD_BITS:0]      d [3],
  input  wire logic        [COORD_BITS:0]      dmag [3],
  input  wire logic                            sep_in,
  output logic signed [2*COORD_BITS+3:0]       diff_r [3],
  output logic signed [2*COORD_BITS+3:0]       rad_r [3],
  output logic                                 sep_r
);

  localparam int PW = 2 * COORD_BITS + 4;

  logic signed [PW-1:0] ptd_nxt [3];
  logic signed [PW-1:0] pdt_nxt [3];
  logic signed [PW-1:0] pe_a_nxt [3];
  logic signed [PW-1:0] pe_b_nxt [3];
  logic signed [PW-1:0] ptd_r [3];
  logic signed [PW-1:0] pdt_r [3];
  logic signed [PW-1:0] pe_a_r [3];
  logic signed [PW-1:0] pe_b_r [3];
  logic                 sep_m_r;
  logic signed [PW-1:0] diff_nxt [3];
  logic signed [PW-1:0] rad_nxt [3];

  // axis (a,b): distance t_a*d_b - t_b*d_a, radius e_a*|d_b| + e_b*|d_a|
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ptd_nxt[k]  = PW'(t[sbot_pkg::AXIS_A[k]]) * PW'(d[sbot_pkg::AXIS_B[k]]);
      pdt_nxt[k]  = PW'(t[sbot_pkg::AXIS_B[k]]) * PW'(d[sbot_pkg::AXIS_A[k]]);
      pe_a_nxt[k] = PW'(e[sbot_pkg::AXIS_A[k]]) *
                    PW'($signed({1'b0, dmag[sbot_pkg::AXIS_B[k]]}));
      pe_b_nxt[k] = PW'(e[sbot_pkg::AXIS_B[k]]) *
                    PW'($signed({1'b0, dmag[sbot_pkg::AXIS_A[k]]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      ptd_r   <= ptd_nxt;
      pdt_r   <= pdt_nxt;
      pe_a_r  <= pe_a_nxt;
      pe_b_r  <= pe_b_nxt;
      sep_m_r <= sep_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = ptd_r[k] - pdt_r[k];
      rad_nxt[k]  = pe_a_r[k] + pe_b_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      diff_r <= diff_nxt;
      rad_r  <= rad_nxt;
      sep_r  <= sep_m_r;
    end
  end

endmodule

`default_nettype wire
